@@ hw/rtl/brf_pkg.sv @@
// Shared types, constants and helpers for the byte ring FIFO.
// No dependencies; all other files but brf_ram refer to it by scoped names.
package brf_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int PEEK_MAX_DEF = 64;

  localparam int SZ_W   = 9;   // sizes, counts, pointers (pointer < size <= 511)
  localparam int BYTE_W = 8;
  localparam int LEFT_W = 7;   // bytes still to read for one peek, up to 64

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [1:0] REQ_PUSH  = 2'd0;
  localparam logic [1:0] REQ_PEEK  = 2'd1;
  localparam logic [1:0] REQ_POP   = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  // One command from the front end to the back end.
  typedef struct packed {
    logic              is_peek;
    logic [SZ_W-1:0]   done;
    logic [SZ_W-1:0]   pos;
    logic [SZ_W-1:0]   occ;
    logic [SZ_W-1:0]   free;
    logic              empty;
  } cmd_t;

  // Byte store write request.
  typedef struct packed {
    logic              en;
    logic [SZ_W-1:0]   pos;
    logic [BYTE_W-1:0] data;
  } wr_t;

  // Advance a ring position by one slot, wrapping at the size in use.
  function automatic logic [SZ_W-1:0] wrap_inc(input logic [SZ_W-1:0] pos,
                                               input logic [SZ_W-1:0] size);
    logic [SZ_W:0] nxt;
    nxt = {1'b0, pos} + {{SZ_W{1'b0}}, 1'b1};
    if (nxt >= {1'b0, size}) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = nxt[SZ_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/brf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Read data holds while no read is issued. No dependencies.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/brf_front.sv @@
// Front end: accepts requests, keeps the ring pointers and occupancy, writes pushed
// bytes and hands one command per request to the queue. Depends on brf_pkg.
module brf_front #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int PEEK_MAX = brf_pkg::PEEK_MAX_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_req_type,
  input  logic [brf_pkg::BYTE_W-1:0] in_push_byte,
  input  logic [brf_pkg::SZ_W-1:0]  in_request_count,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [brf_pkg::SZ_W-1:0]  cfg_buffer_size,
  input  logic                      q_full,
  input  logic                      peek_done,
  output logic                      enq,
  output brf_pkg::cmd_t             enq_cmd,
  output brf_pkg::wr_t              wr,
  output logic [brf_pkg::SZ_W-1:0]  size
);

  localparam int SZ_W = brf_pkg::SZ_W;
  localparam logic [31:0] DEPTH_U = 32'(DEPTH);
  localparam logic [SZ_W-1:0] RST_SIZE = (DEPTH < 256) ? SZ_W'(DEPTH) : SZ_W'(256);
  localparam logic [SZ_W-1:0] PK_MAX = SZ_W'(PEEK_MAX);

  logic [SZ_W-1:0] size_r, size_nxt;
  logic [SZ_W-1:0] head_r, head_nxt;
  logic [SZ_W-1:0] tail_r, tail_nxt;
  logic [SZ_W-1:0] occ_r, occ_nxt;
  logic [brf_pkg::QCNT_W-1:0] peeks_r, peeks_nxt;

  logic            accept;
  logic            cfg_wr;
  logic [SZ_W-1:0] cfg_clamp;
  logic [SZ_W-1:0] n;
  logic [SZ_W:0]   tsum;
  logic [SZ_W:0]   twrap;
  logic            peek_go;

  // Hold pushes while a peek still reads the store: a pop and push could overwrite it.
  assign in_stall  = q_full || ((in_req_type == brf_pkg::REQ_PUSH) && (peeks_r != '0));
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign size      = size_r;

  always_comb begin
    if (cfg_buffer_size == '0) begin
      cfg_clamp = SZ_W'(1);
    end else if (32'(cfg_buffer_size) > DEPTH_U) begin
      cfg_clamp = SZ_W'(DEPTH);
    end else begin
      cfg_clamp = cfg_buffer_size;
    end
  end

  assign tsum  = {1'b0, tail_r} + {1'b0, in_request_count};
  assign twrap = (tsum >= {1'b0, size_r}) ? (tsum - {1'b0, size_r}) : tsum;

  always_comb begin
    size_nxt = size_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    n        = '0;
    peek_go  = 1'b0;
    wr.en    = 1'b0;
    wr.pos   = head_r;
    wr.data  = in_push_byte;
    if (cfg_wr) begin
      size_nxt = cfg_clamp;
      head_nxt = '0;
      tail_nxt = '0;
      occ_nxt  = '0;
    end else if (accept) begin
      case (in_req_type)
        brf_pkg::REQ_PUSH: begin
          if (occ_r < size_r) begin
            wr.en    = 1'b1;
            head_nxt = brf_pkg::wrap_inc(head_r, size_r);
            occ_nxt  = occ_r + SZ_W'(1);
            n        = SZ_W'(1);
          end
        end
        brf_pkg::REQ_PEEK: begin
          n = in_request_count;
          if (n > occ_r) begin
            n = occ_r;
          end
          if (n > PK_MAX) begin
            n = PK_MAX;
          end
          peek_go = (n != '0);
        end
        brf_pkg::REQ_POP: begin
          if (in_request_count != '0) begin
            if (in_request_count >= occ_r) begin
              n        = occ_r;
              head_nxt = '0;
              tail_nxt = '0;
              occ_nxt  = '0;
            end else begin
              n        = in_request_count;
              tail_nxt = twrap[SZ_W-1:0];
              occ_nxt  = occ_r - in_request_count;
            end
          end
        end
        default: begin
          head_nxt = '0;
          tail_nxt = '0;
          occ_nxt  = '0;
        end
      endcase
    end
  end

  always_comb begin
    enq             = accept;
    enq_cmd.is_peek = peek_go;
    enq_cmd.done    = n;
    enq_cmd.pos     = tail_r;
    enq_cmd.occ     = occ_nxt;
    enq_cmd.free    = size_r - occ_nxt;
    enq_cmd.empty   = (occ_nxt == '0);
  end

  always_comb begin
    peeks_nxt = peeks_r;
    if (accept && peek_go && !peek_done) begin
      peeks_nxt = peeks_r + brf_pkg::QCNT_W'(1);
    end else if (!(accept && peek_go) && peek_done) begin
      peeks_nxt = peeks_r - brf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= RST_SIZE;
      head_r  <= '0;
      tail_r  <= '0;
      occ_r   <= '0;
      peeks_r <= '0;
    end else begin
      size_r  <= size_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      occ_r   <= occ_nxt;
      peeks_r <= peeks_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= size_r)
    else $error("occupancy exceeds buffer size");

  a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r < size_r) && (tail_r < size_r))
    else $error("ring pointer outside buffer size");

endmodule

@@ hw/rtl/brf_queue.sv @@
// Short command queue between the front and back ends, built from flops.
// Depends on brf_pkg for the command type and depth.
module brf_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  brf_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output brf_pkg::cmd_t head_cmd
);

  brf_pkg::cmd_t entry_r [brf_pkg::QDEPTH];
  logic [brf_pkg::QPTR_W-1:0] wp_r, wp_nxt;
  logic [brf_pkg::QPTR_W-1:0] rp_r, rp_nxt;
  logic [brf_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == brf_pkg::QCNT_W'(brf_pkg::QDEPTH));
  assign valid    = (cnt_r != '0);
  assign head_cmd = entry_r[rp_r];

  always_comb begin
    wp_nxt  = push ? (wp_r + brf_pkg::QPTR_W'(1)) : wp_r;
    rp_nxt  = pop ? (rp_r + brf_pkg::QPTR_W'(1)) : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + brf_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - brf_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> !full)
    else $error("command queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> valid)
    else $error("command queue underflow");

endmodule

@@ hw/rtl/brf_back.sv @@
// Back end: takes commands from the queue, reads peeked bytes from the store one per
// cycle unless the output stalls and drives the result register. Depends on brf_pkg.
module brf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  brf_pkg::cmd_t              q_cmd,
  output logic                       q_pop,
  input  logic [brf_pkg::SZ_W-1:0]   size,
  output logic                       rd_en,
  output logic [brf_pkg::SZ_W-1:0]   rd_pos,
  input  logic [brf_pkg::BYTE_W-1:0] rd_data,
  output logic                       peek_done,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brf_pkg::BYTE_W-1:0] out_byte,
  output logic [brf_pkg::SZ_W-1:0]   out_done_count,
  output logic                       out_last,
  output logic [brf_pkg::SZ_W-1:0]   out_occupancy,
  output logic [brf_pkg::SZ_W-1:0]   out_free_space,
  output logic                       out_is_empty
);

  localparam int SZ_W   = brf_pkg::SZ_W;
  localparam int LEFT_W = brf_pkg::LEFT_W;

  logic                act_r, act_nxt;
  logic [SZ_W-1:0]     pos_r, pos_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  brf_pkg::cmd_t       acmd_r;
  logic                pend_r, pend_nxt;
  logic                plast_r, plast_nxt;

  logic                ovalid_r, ovalid_nxt;
  logic [brf_pkg::BYTE_W-1:0] obyte_r;
  logic [SZ_W-1:0]     odone_r, oocc_r, ofree_r;
  logic                olast_r, oempty_r;

  logic out_load, move, issue, take_single, take_peek;

  assign out_load    = !ovalid_r || !out_stall;
  assign move        = pend_r && out_load;
  assign issue       = act_r && (!pend_r || move);
  assign take_single = q_valid && !q_cmd.is_peek && !act_r && !pend_r && out_load;
  assign take_peek   = q_valid && q_cmd.is_peek && !act_r && !pend_r;
  assign q_pop       = take_single || take_peek;
  assign rd_en       = issue;
  assign rd_pos      = pos_r;
  assign peek_done   = move && plast_r;

  always_comb begin
    act_nxt   = act_r;
    pos_nxt   = pos_r;
    left_nxt  = left_r;
    pend_nxt  = pend_r;
    plast_nxt = plast_r;
    if (take_peek) begin
      act_nxt  = 1'b1;
      pos_nxt  = q_cmd.pos;
      left_nxt = q_cmd.done[LEFT_W-1:0];
    end else if (issue) begin
      pos_nxt   = brf_pkg::wrap_inc(pos_r, size);
      left_nxt  = left_r - LEFT_W'(1);
      act_nxt   = (left_r != LEFT_W'(1));
      pend_nxt  = 1'b1;
      plast_nxt = (left_r == LEFT_W'(1));
    end else if (move) begin
      pend_nxt = 1'b0;
    end
  end

  assign ovalid_nxt = (move || take_single) ? 1'b1 : (out_load ? 1'b0 : ovalid_r);

  always_ff @(posedge clk) begin
    if (take_peek) begin
      acmd_r <= q_cmd;
    end
    if (move) begin
      obyte_r  <= rd_data;
      odone_r  <= acmd_r.done;
      olast_r  <= plast_r;
      oocc_r   <= acmd_r.occ;
      ofree_r  <= acmd_r.free;
      oempty_r <= acmd_r.empty;
    end else if (take_single) begin
      obyte_r  <= '0;
      odone_r  <= q_cmd.done;
      olast_r  <= 1'b1;
      oocc_r   <= q_cmd.occ;
      ofree_r  <= q_cmd.free;
      oempty_r <= q_cmd.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r    <= 1'b0;
      pos_r    <= '0;
      left_r   <= '0;
      pend_r   <= 1'b0;
      plast_r  <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      act_r    <= act_nxt;
      pos_r    <= pos_nxt;
      left_r   <= left_nxt;
      pend_r   <= pend_nxt;
      plast_r  <= plast_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_valid      = ovalid_r;
  assign out_byte       = obyte_r;
  assign out_done_count = odone_r;
  assign out_last       = olast_r;
  assign out_occupancy  = oocc_r;
  assign out_free_space = ofree_r;
  assign out_is_empty   = oempty_r;

  a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    act_r |-> (left_r != '0))
    else $error("peek active with no bytes left");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    peek_done |-> !act_r)
    else $error("final peek byte delivered while reads remain");

endmodule

@@ hw/rtl/byte_ring_fifo_peek_pop.sv @@
// Top level of the byte ring FIFO with peek and pop.
// Ties together brf_front, brf_queue, brf_back and brf_ram; uses brf_pkg.
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_req_type, in_push_byte, in_request_count
//   out_     output     out_valid/out_stall out_byte, out_done_count, out_last,
//                                          out_occupancy, out_free_space, out_is_empty
//   cfg_     input      cfg_valid/cfg_ready cfg_buffer_size
//
// Push, pop and clear take one item per cycle unless stalled; each gives one result.
// A peek of n bytes gives n results, one per cycle unless stalled, paced by the single
// store read port. A push waits while a peek is still reading the store; the command
// queue holds four. Reset is synchronous and needs no clearing pass; the store is
// undefined until written. A stalled output holds its result; requests are still taken.
module byte_ring_fifo_peek_pop #(
  parameter int DEPTH    = brf_pkg::DEPTH_DEF,
  parameter int PEEK_MAX = brf_pkg::PEEK_MAX_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_req_type,
  input  logic [brf_pkg::BYTE_W-1:0] in_push_byte,
  input  logic [brf_pkg::SZ_W-1:0]   in_request_count,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [brf_pkg::BYTE_W-1:0] out_byte,
  output logic [brf_pkg::SZ_W-1:0]   out_done_count,
  output logic                       out_last,
  output logic [brf_pkg::SZ_W-1:0]   out_occupancy,
  output logic [brf_pkg::SZ_W-1:0]   out_free_space,
  output logic                       out_is_empty,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [brf_pkg::SZ_W-1:0]   cfg_buffer_size
);

  localparam int AW   = $clog2(DEPTH);
  localparam int SZ_W = brf_pkg::SZ_W;

  logic                       q_full, q_valid, q_pop, enq, peek_done;
  brf_pkg::cmd_t              enq_cmd, q_cmd;
  brf_pkg::wr_t               wr;
  logic [SZ_W-1:0]            size;
  logic                       rd_en;
  logic [SZ_W-1:0]            rd_pos;
  logic [brf_pkg::BYTE_W-1:0] rd_data;
  logic [AW+SZ_W-1:0]         wext, rext;

  brf_front #(.DEPTH(DEPTH), .PEEK_MAX(PEEK_MAX)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_push_byte     (in_push_byte),
    .in_request_count (in_request_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_buffer_size  (cfg_buffer_size),
    .q_full           (q_full),
    .peek_done        (peek_done),
    .enq              (enq),
    .enq_cmd          (enq_cmd),
    .wr               (wr),
    .size             (size)
  );

  brf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (enq),
    .push_cmd (enq_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (q_cmd)
  );

  brf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_cmd          (q_cmd),
    .q_pop          (q_pop),
    .size           (size),
    .rd_en          (rd_en),
    .rd_pos         (rd_pos),
    .rd_data        (rd_data),
    .peek_done      (peek_done),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_done_count (out_done_count),
    .out_last       (out_last),
    .out_occupancy  (out_occupancy),
    .out_free_space (out_free_space),
    .out_is_empty   (out_is_empty)
  );

  // Ring positions stay below the size in use, so they fit the store address width.
  assign wext = {{AW{1'b0}}, wr.pos};
  assign rext = {{AW{1'b0}}, rd_pos};

  brf_ram #(.WIDTH(brf_pkg::BYTE_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wext[AW-1:0]),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rext[AW-1:0]),
    .rdata (rd_data)
  );

endmodule

@@ tb/tb_byte_ring_fifo_peek_pop.sv @@
// Self-checking testbench for the byte ring FIFO with peek and pop.
// Drives push, peek, pop and clear requests and size writes, predicts each result in place.
// Depends on brf_pkg and byte_ring_fifo_peek_pop from the RTL.
module tb_byte_ring_fifo_peek_pop;

  localparam int RING_DEPTH = brf_pkg::DEPTH_DEF;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int PEEK_LIMIT = brf_pkg::PEEK_MAX_DEF;
  localparam int BYTE_W     = brf_pkg::BYTE_W;
  localparam int SZ_W       = brf_pkg::SZ_W;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic [SZ_W-1:0]   done;
    logic              last;
    logic [SZ_W-1:0]   occ;
    logic [SZ_W-1:0]   free;
    logic              empty;
  } ring_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_req_type = brf_pkg::REQ_PUSH;
  logic [BYTE_W-1:0] in_push_byte = '0;
  logic [SZ_W-1:0]   in_request_count = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic [SZ_W-1:0]   out_done_count;
  logic              out_last;
  logic [SZ_W-1:0]   out_occupancy;
  logic [SZ_W-1:0]   out_free_space;
  logic              out_is_empty;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [SZ_W-1:0]   cfg_buffer_size = '0;

  // Predicted ring contents and pointers
  logic [BYTE_W-1:0] ring_bytes [RING_DEPTH];
  int unsigned       ring_head = 0;
  int unsigned       ring_tail = 0;
  int unsigned       ring_size = RING_DEPTH;
  bit                ring_is_empty = 1'b1;

  ring_result_t      results_due [$];

  int unsigned       in_idle_pct = 0;
  int unsigned       out_stall_pct = 0;
  int unsigned       error_count = 0;
  int unsigned       items_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       peek_bytes = 0;
  int unsigned       size_writes = 0;

  byte_ring_fifo_peek_pop uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_req_type      (in_req_type),
    .in_push_byte     (in_push_byte),
    .in_request_count (in_request_count),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_done_count   (out_done_count),
    .out_last         (out_last),
    .out_occupancy    (out_occupancy),
    .out_free_space   (out_free_space),
    .out_is_empty     (out_is_empty),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_buffer_size  (cfg_buffer_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= rst_n ? ($urandom_range(99) < out_stall_pct) : 1'b0;
  end

  task automatic report_mismatch(string msg);
    error_count++;
    if (error_count <= 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic int unsigned ring_occupancy();
    if (ring_is_empty) begin
      return 0;
    end
    if (ring_head > ring_tail) begin
      return ring_head - ring_tail;
    end
    return ring_size - (ring_tail - ring_head);
  endfunction

  function automatic int unsigned ring_advance(int unsigned pos, int unsigned n);
    int unsigned p;
    p = pos + n;
    while (p >= ring_size) begin
      p -= ring_size;
    end
    return p;
  endfunction

  function automatic void ring_reset_pointers();
    ring_head = 0;
    ring_tail = 0;
    ring_is_empty = 1'b1;
  endfunction

  function automatic void queue_result(int unsigned data, int unsigned done, bit last);
    ring_result_t r;
    int unsigned  occ;
    occ = ring_occupancy();
    r.data = data[BYTE_W-1:0];
    r.done = done[SZ_W-1:0];
    r.last = last;
    r.occ = occ[SZ_W-1:0];
    r.free = SZ_W'(ring_size - occ);
    r.empty = ring_is_empty;
    results_due.push_back(r);
  endfunction

  // Update the ring for one accepted request and queue the results it causes.
  function automatic void apply_request(logic [1:0] kind, logic [BYTE_W-1:0] pb,
                                        logic [SZ_W-1:0] cnt);
    int unsigned occ;
    int unsigned n;
    int unsigned pos;
    occ = ring_occupancy();
    n = 0;
    case (kind)
      brf_pkg::REQ_PUSH: begin
        if (occ < ring_size) begin
          ring_bytes[RING_AW'(ring_head)] = pb;
          ring_head = ring_advance(ring_head, 1);
          ring_is_empty = 1'b0;
          n = 1;
        end
        queue_result(0, n, 1'b1);
      end
      brf_pkg::REQ_PEEK: begin
        n = 32'(cnt);
        if (n > occ) n = occ;
        if (n > PEEK_LIMIT) n = PEEK_LIMIT;
        if (n == 0) begin
          queue_result(0, 0, 1'b1);
        end else begin
          pos = ring_tail;
          for (int i = 0; i < n; i++) begin
            queue_result(32'(ring_bytes[RING_AW'(pos)]), n, (i + 1) == n);
            pos = ring_advance(pos, 1);
          end
        end
        peek_bytes += n;
      end
      brf_pkg::REQ_POP: begin
        if (cnt != 0) begin
          if (cnt >= occ) begin
            n = occ;
            ring_reset_pointers();
          end else begin
            n = 32'(cnt);
            ring_tail = ring_advance(ring_tail, n);
            if (ring_tail == ring_head) ring_reset_pointers();
          end
        end
        queue_result(0, n, 1'b1);
      end
      default: begin
        ring_reset_pointers();
        queue_result(0, 0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk) begin : result_check
    ring_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result byte=%0h done=%0d last=%0b occ=%0d",
                                  out_byte, out_done_count, out_last, out_occupancy));
      end else begin
        want = results_due.pop_front();
        results_seen++;
        if (out_byte !== want.data || out_done_count !== want.done ||
            out_last !== want.last || out_occupancy !== want.occ ||
            out_free_space !== want.free || out_is_empty !== want.empty) begin
          report_mismatch($sformatf(
            "got %0h %0d %0b %0d %0d %0b, want %0h %0d %0b %0d %0d %0b",
            out_byte, out_done_count, out_last, out_occupancy, out_free_space, out_is_empty,
            want.data, want.done, want.last, want.occ, want.free, want.empty));
        end
      end
    end
  end

  // Present one request, hold it until accepted, then predict it.
  task automatic send_request(logic [1:0] kind, logic [BYTE_W-1:0] pb, logic [SZ_W-1:0] cnt);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_push_byte <= pb;
    in_request_count <= cnt;
    do @(posedge clk); while (in_stall !== 1'b0);
    apply_request(kind, pb, cnt);
    items_sent++;
  endtask

  task automatic push_bytes(int unsigned n);
    repeat (n) send_request(brf_pkg::REQ_PUSH, 8'($urandom_range(255)),
                            9'($urandom_range(256)));
  endtask

  // Drop valid and let every expected result drain, then let the pipeline settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_buffer_size(logic [SZ_W-1:0] value);
    int unsigned v;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_buffer_size <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    v = 32'(value);
    if (v < 1) v = 1;
    if (v > RING_DEPTH) v = RING_DEPTH;
    ring_size = v;
    ring_reset_pointers();
    size_writes++;
  endtask

  function automatic logic [SZ_W-1:0] pick_count();
    int unsigned occ;
    int unsigned c;
    occ = ring_occupancy();
    case ($urandom_range(3))
      0: c = $urandom_range(3);
      1: c = ((occ == 0) ? 0 : occ - 1) + $urandom_range(2);
      2: c = $urandom_range(256);
      default: c = $urandom_range(1) ? 256 : 63 + $urandom_range(2);
    endcase
    if (c > 256) c = 256;
    return c[SZ_W-1:0];
  endfunction

  // Mostly push bursts followed by peeks and pops, with clears as noise.
  task automatic run_traffic(int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 45) begin
        push_bytes($urandom_range(1, (ring_size < 16) ? ring_size + 2 : 40));
      end else if (r < 70) begin
        send_request(brf_pkg::REQ_PEEK, 8'($urandom_range(255)), pick_count());
      end else if (r < 92) begin
        send_request(brf_pkg::REQ_POP, 8'($urandom_range(255)), pick_count());
      end else begin
        send_request(brf_pkg::REQ_CLEAR, 8'($urandom_range(255)), 9'($urandom_range(256)));
      end
    end
  endtask

  task automatic test_empty_ring();
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd5);
    send_request(brf_pkg::REQ_PEEK, 8'hFF, 9'd0);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd0);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd256);
    send_request(brf_pkg::REQ_CLEAR, 8'hFF, 9'd256);
  endtask

  task automatic test_single_slot();
    write_buffer_size(9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h00, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'hFF, 9'd256);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd0);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd256);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd0);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd256);
    send_request(brf_pkg::REQ_PUSH, 8'hA5, 9'd0);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd1);
  endtask

  task automatic test_wrap_around();
    write_buffer_size(9'd5);
    send_request(brf_pkg::REQ_PUSH, 8'hFF, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h00, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h5A, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'hC3, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h81, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h7E, 9'd0);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd2);
    send_request(brf_pkg::REQ_PUSH, 8'h66, 9'd0);
    send_request(brf_pkg::REQ_PUSH, 8'h77, 9'd0);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd256);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd4);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd1);
    send_request(brf_pkg::REQ_CLEAR, 8'h00, 9'd0);
  endtask

  task automatic test_size_limits();
    write_buffer_size(9'd511);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd64);
    write_buffer_size(9'd300);
    send_request(brf_pkg::REQ_PUSH, 8'h3C, 9'd0);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd65);
  endtask

  // Fill a ring larger than the peek limit, overflow once, and wrap the pointers past the top.
  task automatic test_full_large_ring();
    write_buffer_size(9'd70);
    push_bytes(71);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd256);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd69);
    push_bytes(12);
    send_request(brf_pkg::REQ_PEEK, 8'h00, 9'd40);
    send_request(brf_pkg::REQ_POP, 8'h00, 9'd256);
  endtask

  task automatic test_random_traffic(int unsigned in_pct, int unsigned out_pct,
                                     int unsigned n);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    write_buffer_size(9'($urandom_range(1, 24)));
    run_traffic(n * 2 / 3);
    write_buffer_size(9'($urandom_range(2, 12)));
    run_traffic(n / 6);
    write_buffer_size(9'd256);
    run_traffic(n / 6);
  endtask

  initial begin
    int unsigned guard;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 14;
    out_stall_pct = 46;
    test_empty_ring();
    test_single_slot();
    test_wrap_around();
    test_size_limits();
    test_full_large_ring();

    test_random_traffic(14, 46, 24);
    test_random_traffic(46, 14, 24);
    test_random_traffic(0, 0, 24);

    in_valid <= 1'b0;
    guard = 0;
    while (results_due.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (results_due.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", results_due.size()));
    end

    $display("Covered %0d requests, %0d results checked (%0d peeked bytes), %0d size writes.",
             items_sent, results_seen, peek_bytes, size_writes);
    $display("Mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("tb_byte_ring_fifo_peek_pop: PASS");
    end else begin
      $display("tb_byte_ring_fifo_peek_pop: FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Timeout with %0d results outstanding", results_due.size());
    $display("tb_byte_ring_fifo_peek_pop: FAIL");
    $finish;
  end

endmodule
